[sv/sit_pkg.sv]
`default_nettype none
package sit_pkg;

  localparam int TABLE_DEPTH_DEF = 256;
  localparam int CHROM_W         = 16;
  localparam int POS_W           = 32;

  // one stored interval
  typedef struct packed {
    logic [CHROM_W-1:0] chrom;
    logic [POS_W-1:0]   start_pos;
    logic [POS_W-1:0]   end_pos;
  } entry_t;

  // flags from the shared compare unit
  typedef struct packed {
    logic precedes;      // entry lies wholly ahead of the key on the ordering
    logic same_chrom;    // entry is on the key's sequence
    logic start_le_pos;  // entry start <= key position
    logic start_lt_lim;  // entry start < key limit (end of interval to add)
    logic end_gt_pos;    // entry end > key position
  } cmp_res_t;

  typedef enum logic [1:0] {
    STATUS_OK      = 2'd0,
    STATUS_EMPTY   = 2'd1,
    STATUS_OVERLAP = 2'd2,
    STATUS_FULL    = 2'd3
  } status_t;

  typedef enum logic {
    FUNC_ADD   = 1'b0,
    FUNC_QUERY = 1'b1
  } func_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CACHE,
    ST_SEARCH,
    ST_PROBE,
    ST_RESOLVE,
    ST_SH_RD,
    ST_SH_WR,
    ST_INSERT,
    ST_DONE
  } state_t;

endpackage
`default_nettype wire

[sv/sit_mem.sv]
`default_nettype none
module sit_mem #(
  parameter int DEPTH  = 256,
  parameter int ADDR_W = 8
) (
  input  wire logic            clk,
  input  wire logic            we,
  input  wire logic [ADDR_W-1:0] waddr,
  input  wire sit_pkg::entry_t wdata,
  input  wire logic [ADDR_W-1:0] raddr,
  output sit_pkg::entry_t      rdata
);
  import sit_pkg::*;

  entry_t mem [DEPTH];

  // write one entry, read one entry, registered read data
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

[sv/sit_cmp.sv]
`default_nettype none
module sit_cmp (
  input  wire sit_pkg::entry_t       entry,
  input  wire logic [sit_pkg::CHROM_W-1:0] key_chrom,
  input  wire logic [sit_pkg::POS_W-1:0]   key_pos,
  input  wire logic [sit_pkg::POS_W-1:0]   key_lim,
  output sit_pkg::cmp_res_t          res
);
  import sit_pkg::*;

  // compare one entry read from the table against the search key
  always_comb begin
    res.same_chrom   = (entry.chrom == key_chrom);
    res.precedes     = (entry.chrom < key_chrom) ||
                       (res.same_chrom && (entry.end_pos <= key_pos));
    res.start_le_pos = (entry.start_pos <= key_pos);
    res.start_lt_lim = (entry.start_pos < key_lim);
    res.end_gt_pos   = (entry.end_pos > key_pos);
  end

endmodule
`default_nettype wire

[sv/sorted_interval_table_top.sv]
`default_nettype none
// Sorted interval table.
// Input stream (s_*): one beat per command. s_tuser is the function (0 add
// interval, 1 query position); s_tdata carries sequence id, start, end and
// query position. Output stream (m_*): exactly one result beat per command
// with status, covered flag and the low 8 bits of the interval index.
// Commands are handled one at a time; s_tready is high only while the
// sequencer is idle. Lookups run a binary search over a table memory with one
// read and one write port, one probe per cycle through one shared compare unit.
// A query first tries the last-hit cache when it is valid; on a cache hit it
// is done, otherwise it runs the binary search (also when a cached entry was
// tried and missed). Add: the same search, then each entry above the slot is
// read and written one place up to open the slot, then the new entry is
// written. An empty interval skips the search; an overlap or a full table returns after the search.
// The result beat appears in the same cycle as the sequencer is back in idle and can take the next command.
// The result sits in an output register; the next command is taken and
// worked on while it waits, and the sequencer holds only when a second
// result is ready before the first was taken.
// Reset empties the table (entry count zero) and clears the cache; memory
// contents are not cleared and no clearing pass is needed.
module sorted_interval_table_top #(
  parameter int TABLE_DEPTH = sit_pkg::TABLE_DEPTH_DEF
) (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         s_tvalid,
  output logic              s_tready,
  // [15:0] chrom_id, [47:16] start_pos, [79:48] end_pos, [111:80] query_pos
  input  wire logic [111:0] s_tdata,
  // [0] func
  input  wire logic         s_tuser,
  output logic              m_tvalid,
  input  wire logic         m_tready,
  // [1:0] status, [2] covered, [10:3] hit_index, [15:11] zero
  output logic [15:0]       m_tdata
);
  import sit_pkg::*;

  localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

  state_t state, state_next;

  // latched command
  logic               func_q;
  logic [CHROM_W-1:0] key_chrom;
  logic [POS_W-1:0]   key_start;
  logic [POS_W-1:0]   key_end;
  logic [POS_W-1:0]   key_qpos;

  // search and table state
  logic [CNT_W-1:0] lo, hi, mid_q, ptr, count;
  logic             found, hit_match;
  logic             cache_valid;
  logic [IDX_W-1:0] cache_index;

  // result
  status_t          res_status;
  logic             res_covered;
  logic [IDX_W-1:0] res_index;

  // memory port
  logic             mem_we;
  logic [IDX_W-1:0] mem_waddr, mem_raddr;
  entry_t           mem_wdata, mem_rdata, new_entry;

  cmp_res_t         cmp;
  logic [POS_W-1:0] key_pos;

  logic [CNT_W-1:0] mid_s, lo_n, hi_n, mid_n, ptr_m1;
  logic [CNT_W-1:0] cache_ext;
  logic [IDX_W+7:0] idx_ext;
  logic             cache_hit, in_empty, out_free;

  assign key_pos   = func_q ? key_qpos : key_start;
  assign new_entry = '{chrom: key_chrom, start_pos: key_start, end_pos: key_end};
  assign in_empty  = (s_tdata[47:16] >= s_tdata[79:48]);
  assign cache_ext = CNT_W'(cache_index);
  assign cache_hit = cmp.same_chrom && cmp.start_le_pos && cmp.end_gt_pos;
  assign out_free  = !m_tvalid || m_tready;
  assign idx_ext   = {8'b0, res_index};
  assign ptr_m1    = ptr - 1'b1;

  // midpoints: first probe, and the following probe after this compare
  always_comb begin
    mid_s = lo + ((hi - lo) >> 1);
    if (cmp.precedes) begin
      lo_n = mid_q + 1'b1;
      hi_n = hi;
    end else begin
      lo_n = lo;
      hi_n = mid_q;
    end
    mid_n = lo_n + ((hi_n - lo_n) >> 1);
  end

  sit_mem #(
    .DEPTH  (TABLE_DEPTH),
    .ADDR_W (IDX_W)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  sit_cmp u_cmp (
    .entry     (mem_rdata),
    .key_chrom (key_chrom),
    .key_pos   (key_pos),
    .key_lim   (key_end),
    .res       (cmp)
  );

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (s_tvalid) begin
          if (s_tuser == FUNC_ADD) begin
            state_next = in_empty ? ST_DONE : ST_SEARCH;
          end else if (cache_valid && (cache_ext < count)) begin
            state_next = ST_CACHE;
          end else begin
            state_next = ST_SEARCH;
          end
        end
      end
      ST_CACHE:   state_next = cache_hit ? ST_DONE : ST_SEARCH;
      ST_SEARCH:  state_next = (lo < hi) ? ST_PROBE : ST_RESOLVE;
      ST_PROBE:   state_next = (lo_n < hi_n) ? ST_PROBE : ST_RESOLVE;
      ST_RESOLVE: begin
        if (func_q == FUNC_QUERY) begin
          state_next = ST_DONE;
        end else if (found && hit_match) begin
          state_next = ST_DONE;
        end else if (count == CNT_W'(TABLE_DEPTH)) begin
          state_next = ST_DONE;
        end else if (lo == count) begin
          state_next = ST_INSERT;
        end else begin
          state_next = ST_SH_RD;
        end
      end
      ST_SH_RD:   state_next = ST_SH_WR;
      ST_SH_WR:   state_next = (ptr_m1 == lo) ? ST_INSERT : ST_SH_RD;
      ST_INSERT:  state_next = ST_DONE;
      ST_DONE:    state_next = out_free ? ST_IDLE : ST_DONE;
      default:    state_next = ST_IDLE;
    endcase
  end

  // outputs of the sequencer: handshake and memory port
  always_comb begin
    s_tready  = (state == ST_IDLE);
    mem_raddr = cache_index;
    mem_we    = 1'b0;
    mem_waddr = lo[IDX_W-1:0];
    mem_wdata = new_entry;
    case (state)
      ST_SEARCH: mem_raddr = mid_s[IDX_W-1:0];
      ST_PROBE:  mem_raddr = mid_n[IDX_W-1:0];
      ST_SH_RD:  mem_raddr = ptr_m1[IDX_W-1:0];
      ST_SH_WR: begin
        mem_we    = 1'b1;
        mem_waddr = ptr[IDX_W-1:0];
        mem_wdata = mem_rdata;
      end
      ST_INSERT: mem_we = 1'b1;
      default: ;
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      count       <= '0;
      cache_valid <= 1'b0;
      cache_index <= '0;
      m_tvalid    <= 1'b0;
    end else begin
      state <= state_next;
      // load a new beat when the output frees up, else drop the taken one
      if ((state == ST_DONE) && out_free) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (s_tvalid && (s_tuser == FUNC_ADD)) begin
            cache_valid <= 1'b0;
          end
        end
        ST_RESOLVE: begin
          if ((func_q == FUNC_QUERY) && found && hit_match) begin
            cache_valid <= 1'b1;
            cache_index <= lo[IDX_W-1:0];
          end
        end
        ST_INSERT: count <= count + 1'b1;
        default: ;
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        func_q      <= s_tuser;
        key_chrom   <= s_tdata[15:0];
        key_start   <= s_tdata[47:16];
        key_end     <= s_tdata[79:48];
        key_qpos    <= s_tdata[111:80];
        lo          <= '0;
        hi          <= count;
        found       <= 1'b0;
        hit_match   <= 1'b0;
        res_covered <= 1'b0;
        res_index   <= '0;
        res_status  <= (s_tuser == FUNC_ADD && in_empty) ? STATUS_EMPTY : STATUS_OK;
      end
      ST_CACHE: begin
        if (cache_hit) begin
          res_covered <= 1'b1;
          res_index   <= cache_index;
        end
      end
      ST_SEARCH: mid_q <= mid_s;
      ST_PROBE: begin
        lo    <= lo_n;
        hi    <= hi_n;
        mid_q <= mid_n;
        if (!cmp.precedes) begin
          found     <= 1'b1;
          hit_match <= (func_q == FUNC_QUERY) ? (cmp.same_chrom && cmp.start_le_pos)
                                              : (cmp.same_chrom && cmp.start_lt_lim);
        end
      end
      ST_RESOLVE: begin
        ptr <= count;
        if (func_q == FUNC_QUERY) begin
          if (found && hit_match) begin
            res_covered <= 1'b1;
            res_index   <= lo[IDX_W-1:0];
          end
        end else if (found && hit_match) begin
          res_status <= STATUS_OVERLAP;
          res_index  <= lo[IDX_W-1:0];
        end else if (count == CNT_W'(TABLE_DEPTH)) begin
          res_status <= STATUS_FULL;
        end else begin
          res_index <= lo[IDX_W-1:0];
        end
      end
      ST_SH_WR: ptr <= ptr_m1;
      ST_DONE: begin
        if (out_free) begin
          m_tdata <= {5'b0, idx_ext[7:0], res_covered, res_status};
        end
      end
      default: ;
    endcase
  end

endmodule
`default_nettype wire
